FILE: sv/ioc_pkg.sv
// Shared types and constants for the immediate operand coder.
package ioc_pkg;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 64;
   localparam int CODING_W = 34;
   localparam int AL_W     = 33;
   localparam int PACK_W   = 28;

   typedef enum logic [KIND_W-1:0] {
      KIND_SHORT_V1 = 2'd0,
      KIND_SHORT_V2 = 2'd1,
      KIND_MAX_LEN  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ALIGN_NONE  = 2'b00,
      ALIGN_STEP1 = 2'b01,
      ALIGN_STEP2 = 2'b10,
      ALIGN_HALF  = 2'b11
   } align_type;

   localparam logic [2:0] LEN_REALIGN_SHORT = 3'd5;
   localparam logic [2:0] LEN_REALIGN_LONG  = 3'd6;
   localparam logic [2:0] LEN_FULL          = 3'd3;

endpackage

FILE: sv/immediate_operand_coder.sv
// Immediate operand coder: input register, single-pass encode, result register.
// A taken transfer passes through the input register, then the result register.
// Throughput: one item per cycle; busy is held low, as the encode path is one pass.
// The rate is set by the single combinational pass between input and result registers.
// Reset clears the input and result strobes; payload registers are not reset.
module immediate_operand_coder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ioc_pkg::KIND_W-1:0]    req_kind,
   input  logic signed [ioc_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [ioc_pkg::CODING_W-1:0]  rsp_coding,
   output logic                          rsp_valid_res
);
   import ioc_pkg::*;

   logic                       req_valid_ff;
   kind_type                   req_kind_ff;
   logic signed [VALUE_W-1:0]  req_value_ff;

   logic                       rsp_strobe_ff;
   logic [CODING_W-1:0]        rsp_coding_ff;
   logic                       rsp_valid_res_ff;
   logic [CODING_W-1:0]        rsp_coding_in;
   logic                       rsp_valid_res_in;

   logic                       in_range;
   logic signed [AL_W-1:0]     x;
   logic signed [AL_W-1:0]     x_sh1;
   logic signed [AL_W-1:0]     x_sh2;
   logic signed [AL_W-1:0]     al;
   logic signed [AL_W-1:0]     w;
   align_type                  abits;
   logic                       use_half;
   logic                       neg;
   logic [PACK_W-1:0]          pack_val;
   logic [PACK_W-1:0]          pack_val_re;
   logic [2:0]                 len;
   logic                       len_ok;
   logic                       realign;
   logic [CODING_W-1:0]        n_short;
   logic                       max_fits;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      if (start) begin
         req_kind_ff  <= kind_type'(req_kind);
         req_value_ff <= req_value;
      end
   end

   always_comb begin
      in_range = (&req_value_ff[VALUE_W-1:AL_W-1]) | (~|req_value_ff[VALUE_W-1:AL_W-1]);
      x        = req_value_ff[AL_W-1:0];
      x_sh1    = x >>> 2;
      x_sh2    = x >>> 4;
      use_half = (req_kind_ff != KIND_SHORT_V2) &&
                 ((x[15:0] == 16'h0000) || (x[15:0] == 16'hFFFF));

      priority if (use_half) begin
         al    = x >>> 15;
         abits = ALIGN_HALF;
      end else if (!((x[2:0] == 3'b000) || (x[2:0] == 3'b111))) begin
         al    = x;
         abits = ALIGN_NONE;
      end else if (!((x_sh1[2:0] == 3'b000) || (x_sh1[2:0] == 3'b111))) begin
         al    = x_sh1;
         abits = ALIGN_STEP1;
      end else begin
         al    = x_sh2;
         abits = ALIGN_STEP2;
      end

      w        = al >>> 4;
      neg      = w[AL_W-1];
      pack_val = {al[3:0], w[7:0], w[15:8], w[23:16]};

      len_ok = 1'b1;
      priority if ((&w) || (~|w)) begin
         len = 3'd0;
      end else if ((&w[AL_W-1:8]) || (~|w[AL_W-1:8])) begin
         len = 3'd1;
      end else if ((&w[AL_W-1:16]) || (~|w[AL_W-1:16])) begin
         len = 3'd2;
      end else if ((&w[AL_W-1:24]) || (~|w[AL_W-1:24])) begin
         len = LEN_FULL;
      end else begin
         len    = 3'd0;
         len_ok = 1'b0;
      end

      realign     = (req_kind_ff == KIND_SHORT_V2) && (len == LEN_FULL) && len_ok &&
                    !neg && (abits == ALIGN_STEP2) && (pack_val[23:16] == 8'h00);
      pack_val_re = {pack_val[27:24], pack_val[7:0], pack_val[15:8], 8'h00};
      if (realign) begin
         len = (pack_val[15:8] != 8'h00) ? LEN_REALIGN_LONG : LEN_REALIGN_SHORT;
      end

      n_short = {1'b1, neg, abits, 2'b00, (realign ? pack_val_re : pack_val)};
      n_short[30:28] = n_short[30:28] | len;

      max_fits = (&al[AL_W-1:PACK_W]) || (~|al[AL_W-1:PACK_W]);

      rsp_coding_in    = '0;
      rsp_valid_res_in = 1'b0;
      if (in_range) begin
         unique case (req_kind_ff)
            KIND_SHORT_V1, KIND_SHORT_V2: begin
               priority if (~|x) begin
                  rsp_valid_res_in = 1'b1;
               end else if (&x) begin
                  rsp_coding_in    = {2'b01, {(CODING_W-2){1'b0}}};
                  rsp_valid_res_in = 1'b1;
               end else if (len_ok) begin
                  rsp_coding_in    = n_short;
                  rsp_valid_res_in = 1'b1;
               end else begin
                  rsp_valid_res_in = 1'b0;
               end
            end
            KIND_MAX_LEN: begin
               if (max_fits) begin
                  rsp_coding_in    = {1'b1, neg, abits, 2'b11, pack_val};
                  rsp_valid_res_in = 1'b1;
               end
            end
            default: begin
               rsp_valid_res_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_coding_ff    <= rsp_coding_in;
         rsp_valid_res_ff <= rsp_valid_res_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_coding    = rsp_coding_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

endmodule

FILE: sim/coding_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the immediate operand coder: coding predictor and store of expected codings.
package coding_scoreboard_pkg;
   import ioc_pkg::*;

   localparam logic [1:0]  KIND_UNUSED     = 2'd3;
   localparam logic [63:0] SIGN_BIT        = 64'h1_0000_0000;
   localparam logic [63:0] STEP_BIT        = 64'h4000_0000;
   localparam logic [63:0] ALIGN_HI        = 64'h8000_0000;
   localparam logic [63:0] REALIGN_MASK    = 64'h1_8000_0000;
   localparam logic [63:0] BASE_HALF_SHORT = 64'd11 << 30;
   localparam logic [63:0] BASE_STEP_SHORT = 64'd8 << 30;
   localparam logic [63:0] BASE_HALF_MAX   = 64'h2F << 28;
   localparam logic [63:0] BASE_STEP_MAX   = 64'h23 << 28;
   localparam longint      RANGE_LIMIT     = 64'sh1_0000_0000;
   localparam longint      FIT_LIMIT       = 64'sh1000_0000;

   typedef struct {
      logic [CODING_W-1:0] coding;
      logic                valid_res;
   } coding_result_type;

   class coding_scoreboard;
      coding_result_type pending_codings[$];
      int                errors;

      function new();
         errors = 0;
      endfunction

      function logic low_uniform(longint v, logic [63:0] mask);
         logic [63:0] lo;
         lo = v & mask;
         return (lo == 64'd0) || (lo == mask);
      endfunction

      function logic [63:0] align_operand(longint value, logic [63:0] base_half,
                                          logic [63:0] base_step, logic allow_half,
                                          output longint shifted);
         logic [63:0] n;
         longint      v;
         v = value;
         if (allow_half && low_uniform(v, 64'hFFFF)) begin
            n = base_half;
            v = v >>> 15;
         end else begin
            n = base_step;
            while (low_uniform(v, 64'h7)) begin
               v = v >>> 2;
               n += STEP_BIT;
               if ((n & ALIGN_HI) != 0) break;
            end
         end
         shifted = v;
         return n;
      endfunction

      function logic [63:0] pack_operand(logic [63:0] base, longint v);
         logic [63:0] n;
         longint      w;
         longint      hi;
         w  = v >>> 4;
         hi = w >>> 16;
         n  = base;
         n |= (v & 64'hF) << 24;
         n |= (w & 64'hFF) << 16;
         n |= w & 64'hFF00;
         n |= hi & 64'hFF;
         return n;
      endfunction

      function coding_result_type encode_immediate(logic [1:0] kind, longint value);
         coding_result_type r;
         logic [63:0]       n;
         longint            v;
         int                len;
         logic              ok;
         logic              second;
         ok  = 1'b0;
         n   = '0;
         len = 0;
         if (value >= -RANGE_LIMIT && value < RANGE_LIMIT) begin
            case (kind)
               KIND_SHORT_V1, KIND_SHORT_V2: begin
                  second = (kind == KIND_SHORT_V2);
                  if (value == 0) begin
                     ok = 1'b1;
                  end else if (value == -1) begin
                     n  = SIGN_BIT;
                     ok = 1'b1;
                  end else begin
                     n = align_operand(value, BASE_HALF_SHORT, BASE_STEP_SHORT, !second, v);
                     n = pack_operand(n, v);
                     v = v >>> 4;
                     if (v < 0) begin
                        n |= SIGN_BIT;
                        while (v < -1) begin
                           v = v >>> 8;
                           len++;
                        end
                     end else begin
                        while (v > 0) begin
                           v = v >>> 8;
                           len++;
                        end
                     end
                     ok = (len <= int'(LEN_FULL));
                     if (ok && second && len == int'(LEN_FULL) &&
                         (n & REALIGN_MASK) == ALIGN_HI && (n & 64'hFF0000) == 0) begin
                        n   = (n | ((n & 64'hFF) << 16)) & ~64'hFF;
                        len = ((n & 64'hFF00) != 0) ? int'(LEN_REALIGN_LONG)
                                                    : int'(LEN_REALIGN_SHORT);
                     end
                     n |= 64'(len) << 28;
                  end
               end
               KIND_MAX_LEN: begin
                  n = align_operand(value, BASE_HALF_MAX, BASE_STEP_MAX, 1'b1, v);
                  if (v >= -FIT_LIMIT && v < FIT_LIMIT) begin
                     n = pack_operand(n, v);
                     if (v < 0) n |= SIGN_BIT;
                     ok = 1'b1;
                  end
               end
               default: ok = 1'b0;
            endcase
         end
         r.valid_res = ok;
         r.coding    = ok ? n[CODING_W-1:0] : '0;
         return r;
      endfunction

      function void note_request(logic [1:0] kind, longint value);
         pending_codings.insert(pending_codings.size(), encode_immediate(kind, value));
      endfunction

      function void check_response(logic [CODING_W-1:0] coding, logic valid_res);
         coding_result_type exp_res;
         if (pending_codings.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual coding %h valid_res %b",
                     $time, coding, valid_res);
            errors++;
            return;
         end
         exp_res = pending_codings.pop_front();
         if (coding !== exp_res.coding) begin
            $display("%0t: coding: expected %h, actual %h", $time, exp_res.coding, coding);
            errors++;
         end
         if (valid_res !== exp_res.valid_res) begin
            $display("%0t: valid_res: expected %b, actual %b",
                     $time, exp_res.valid_res, valid_res);
            errors++;
         end
      endfunction
   endclass

endpackage

FILE: sim/tb_immediate_operand_coder.sv
`timescale 1ns / 100ps
// Testbench top for the immediate operand coder: directed and random transfers, scoreboard check.
module tb_immediate_operand_coder;
   import ioc_pkg::*;
   import coding_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CALM_ITEMS   = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 100000;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        start     = 1'b0;
   logic                        busy;
   logic [KIND_W-1:0]           req_kind  = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_strobe;
   logic [CODING_W-1:0]         rsp_coding;
   logic                        rsp_valid_res;
   int                          cycles    = 0;
   coding_scoreboard            sb;

   always #4 clock = ~clock;

   immediate_operand_coder u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_coding    (rsp_coding),
      .rsp_valid_res (rsp_valid_res)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_response(rsp_coding, rsp_valid_res);
         if (start && !busy) sb.note_request(req_kind, req_value);
      end
   end

   task automatic transfer(logic [1:0] kind, longint value, bit calm);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic longint random_value();
      longint v;
      int     m;
      int     s;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         v = {$urandom, $urandom};
      end else if (pick < 20) begin
         v = longint'($urandom_range(0, 8)) - 4;
         v += $urandom_range(0, 1) ? RANGE_LIMIT : -RANGE_LIMIT;
      end else if (pick < 35) begin
         v = (longint'($urandom_range(1, 255)) << 24) |
             (longint'($urandom_range(0, 1) ? $urandom_range(0, 255) : 0) << 16) |
             (longint'($urandom_range(0, 7)) << 5);
      end else begin
         m = $urandom_range(1, 33);
         v = longint'({$urandom, $urandom}) >>> (64 - m);
         s = $urandom_range(0, 20);
         v = v <<< s;
         if ($urandom_range(0, 1)) v |= (longint'(1) <<< s) - 1;
      end
      return v;
   endfunction

   initial begin
      logic [1:0] kinds[3];
      longint     boundary_values[7];
      logic [1:0] kind;
      kinds = '{KIND_SHORT_V1, KIND_SHORT_V2, KIND_MAX_LEN};
      boundary_values = '{64'sd0, -64'sd1, -RANGE_LIMIT, RANGE_LIMIT - 1, RANGE_LIMIT,
                          64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF};
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (kinds[k])
         foreach (boundary_values[i])
            transfer(kinds[k], boundary_values[i], 1'b0);
      transfer(KIND_SHORT_V2, 64'sh1200_0000, 1'b0);
      transfer(KIND_SHORT_V2, 64'sh1234_0000, 1'b0);
      transfer(KIND_SHORT_V1, 64'sh8765_4321, 1'b0);
      transfer(KIND_MAX_LEN, 64'sh8765_4321, 1'b0);
      transfer(KIND_UNUSED, 64'sd5, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = ($urandom_range(0, 49) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
         transfer(kind, random_value(), n >= RANDOM_ITEMS - CALM_ITEMS);
      end
      start <= 1'b0;

      while (sb.pending_codings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_codings.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
sv/ioc_pkg.sv
sv/immediate_operand_coder.sv
sim/coding_scoreboard_pkg.sv
sim/tb_immediate_operand_coder.sv
